// ----- rtl/dpr_pkg.sv -----
package dpr_pkg;

    localparam int RELAYS = 10;
    localparam int PIN_NIBBLES = 4;
    localparam int MAX_PIN_DIGITS = 4;
    localparam int PIN_CAP = (MAX_PIN_DIGITS < PIN_NIBBLES) ? MAX_PIN_DIGITS : PIN_NIBBLES;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;
    localparam int MAX_RESULTS = 3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    localparam logic [3:0] KEY_HASH = 4'd10;
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_NONE = 4'd15;

    localparam logic [2:0] TONE_NONE     = 3'd0;
    localparam logic [2:0] TONE_OK       = 3'd1;
    localparam logic [2:0] TONE_ERROR    = 3'd2;
    localparam logic [2:0] TONE_NO_RELAY = 3'd3;
    localparam logic [2:0] TONE_WELCOME  = 3'd4;
    localparam logic [2:0] TONE_WARNING  = 3'd5;
    localparam logic [2:0] TONE_ASK_CODE = 3'd6;

    localparam logic [2:0] CFG_KEYS_WITH_RELAY = 3'd0;
    localparam logic [2:0] CFG_WHITELIST_KEYS  = 3'd1;
    localparam logic [2:0] CFG_CALL_TIMEOUT    = 3'd2;
    localparam logic [2:0] CFG_RELAY_PULSE     = 3'd3;
    localparam logic [2:0] CFG_PIN_LENGTHS     = 3'd4;
    localparam logic [2:0] CFG_PIN_DIGITS_0_3  = 3'd5;
    localparam logic [2:0] CFG_PIN_DIGITS_4_7  = 3'd6;
    localparam logic [2:0] CFG_PIN_DIGITS_8_9  = 3'd7;

    localparam logic [19:0] WARN_LEAD_MS = 20'd2000;
    localparam logic [19:0] TIMEOUT_RESET = 20'd30000;
    localparam logic [15:0] PULSE_RESET = 16'd1000;

    typedef struct packed {
        logic       command;
        logic [3:0] key_code;
        logic       call_busy;
        logic       call_connected;
        logic       caller_whitelisted;
    } dpr_in_t;

    typedef struct packed {
        logic [2:0] tone;
        logic [9:0] relay_outputs;
        logic       hang_up;
        logic       last;
    } dpr_out_t;

    typedef struct packed {
        logic [9:0]   keys_with_relay;
        logic [9:0]   whitelist_keys;
        logic [19:0]  call_timeout_ms;
        logic [15:0]  relay_pulse_ms;
        logic [29:0]  pin_lengths;
        logic [159:0] pin_words;
    } dpr_cfg_t;

    typedef struct packed {
        logic [1:0]                   count;
        dpr_out_t [MAX_RESULTS-1:0]   item;
    } dpr_push_t;

endpackage

// ----- rtl/dpr_cfg_regs.sv -----
module dpr_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    output dpr_pkg::dpr_cfg_t cfg
);
    import dpr_pkg::*;

    dpr_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keys_with_relay <= '0;
            cfg_reg.whitelist_keys  <= '0;
            cfg_reg.call_timeout_ms <= TIMEOUT_RESET;
            cfg_reg.relay_pulse_ms  <= PULSE_RESET;
            cfg_reg.pin_lengths     <= '0;
            cfg_reg.pin_words       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEYS_WITH_RELAY: cfg_reg.keys_with_relay <= cfg_data[9:0];
                CFG_WHITELIST_KEYS:  cfg_reg.whitelist_keys  <= cfg_data[9:0];
                CFG_CALL_TIMEOUT:    cfg_reg.call_timeout_ms <= cfg_data[19:0];
                CFG_RELAY_PULSE:     cfg_reg.relay_pulse_ms  <= cfg_data[15:0];
                CFG_PIN_LENGTHS:     cfg_reg.pin_lengths     <= cfg_data[29:0];
                CFG_PIN_DIGITS_0_3:  cfg_reg.pin_words[63:0]    <= cfg_data;
                CFG_PIN_DIGITS_4_7:  cfg_reg.pin_words[127:64]  <= cfg_data;
                CFG_PIN_DIGITS_8_9:  cfg_reg.pin_words[159:128] <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/dpr_core.sv -----
module dpr_core #(
    parameter int NUM_KEYS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_xfer,
    input  dpr_pkg::dpr_in_t   in_item,
    input  dpr_pkg::dpr_cfg_t  cfg,
    output dpr_pkg::dpr_push_t push
);
    import dpr_pkg::*;

    localparam logic [3:0] NUM_KEYS_C = 4'(NUM_KEYS);

    logic        in_call_reg;
    logic [19:0] idle_reg, idle_next;
    logic        warn_reg, warn_next;
    logic        start_done_reg, start_done_next;
    logic [3:0]  pending_reg, pending_next;
    logic [15:0] digits_reg, digits_next;
    logic [2:0]  count_reg, count_next;
    logic [9:0]  active_reg, active_next;
    logic [15:0] elapsed_reg [NUM_KEYS];
    logic [15:0] elapsed_next [NUM_KEYS];

    logic        clear;
    logic        entering;
    logic        is_key;
    logic [3:0]  key;
    logic [19:0] c_idle;
    logic        c_warn;
    logic        c_start;
    logic [3:0]  c_pending;
    logic [15:0] c_digits;
    logic [2:0]  c_count;
    logic [19:0] thr;
    logic [19:0] idle_tick;

    logic [3:0]  pin_key;
    logic [2:0]  len_raw;
    logic [2:0]  pin_len;
    logic [15:0] pin_word;
    logic [15:0] digits_add;
    logic [2:0]  count_inc;
    logic        pin_match;

    logic [2:0]  key_tone;
    logic        fire;
    logic [3:0]  fire_key;

    logic [2:0]  ev_valid;
    logic [2:0]  ev_tone [3];
    logic        ev_hang [3];
    logic [1:0]  n;
    dpr_out_t    slot [3];

    assign is_key   = (in_item.command == CMD_KEY);
    assign key      = in_item.key_code;
    assign clear    = in_item.call_busy ^ in_call_reg;
    assign entering = in_item.call_busy && !in_call_reg;

    assign c_idle    = clear ? '0 : idle_reg;
    assign c_warn    = clear ? 1'b0 : warn_reg;
    assign c_start   = clear ? 1'b0 : start_done_reg;
    assign c_pending = clear ? KEY_NONE : pending_reg;
    assign c_digits  = clear ? '0 : digits_reg;
    assign c_count   = clear ? '0 : count_reg;

    assign thr = (cfg.call_timeout_ms >= WARN_LEAD_MS) ? cfg.call_timeout_ms - WARN_LEAD_MS : '0;
    assign idle_tick = (!entering && (c_idle != '1)) ? c_idle + 20'd1 : c_idle;

    assign pin_key  = (c_pending < NUM_KEYS_C) ? c_pending : key;
    assign len_raw  = cfg.pin_lengths[3*pin_key +: 3];
    assign pin_len  = (len_raw > 3'(PIN_CAP)) ? 3'(PIN_CAP) : len_raw;
    assign pin_word = cfg.pin_words[16*pin_key +: 16];
    assign count_inc = c_count + 3'd1;

    always_comb
    begin
        digits_add = c_digits;
        if (c_count < 3'(PIN_NIBBLES))
        begin
            digits_add[4*c_count[1:0] +: 4] = c_digits[4*c_count[1:0] +: 4] | key;
        end
    end

    always_comb
    begin
        pin_match = (count_inc == pin_len);
        for (int i = 0; i < PIN_NIBBLES; i++)
        begin
            if ((3'(i) < pin_len) && (digits_add[4*i +: 4] != pin_word[4*i +: 4]))
            begin
                pin_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        idle_next       = c_idle;
        warn_next       = c_warn;
        start_done_next = c_start;
        pending_next    = c_pending;
        digits_next     = c_digits;
        count_next      = c_count;
        key_tone        = TONE_NONE;
        fire            = 1'b0;
        fire_key        = key;
        ev_valid        = '0;
        ev_tone[0] = TONE_WELCOME;
        ev_tone[1] = TONE_NONE;
        ev_tone[2] = TONE_NONE;
        ev_hang[0] = 1'b0;
        ev_hang[1] = 1'b0;
        ev_hang[2] = 1'b0;
        if (in_item.call_busy)
        begin
            if (in_item.call_connected && !c_start)
            begin
                ev_valid[0]     = 1'b1;
                start_done_next = 1'b1;
            end
            if (is_key)
            begin
                idle_next = '0;
                warn_next = 1'b0;
                if (in_item.call_connected)
                begin
                    if (key == KEY_HASH)
                    begin
                        ev_valid[1] = 1'b1;
                        ev_hang[1]  = 1'b1;
                    end
                    else if (key <= KEY_LAST_DIGIT)
                    begin
                        if (c_pending < NUM_KEYS_C)
                        begin
                            digits_next = digits_add;
                            count_next  = count_inc;
                            if (count_inc >= pin_len)
                            begin
                                if (!pin_match)
                                begin
                                    key_tone = TONE_ERROR;
                                end
                                else if (cfg.keys_with_relay[c_pending])
                                begin
                                    fire     = 1'b1;
                                    fire_key = c_pending;
                                    key_tone = TONE_OK;
                                end
                                pending_next = KEY_NONE;
                                digits_next  = '0;
                                count_next   = '0;
                            end
                        end
                        else if ((key >= NUM_KEYS_C) || !cfg.keys_with_relay[key])
                        begin
                            key_tone = TONE_NO_RELAY;
                        end
                        else if (cfg.whitelist_keys[key] && !in_item.caller_whitelisted)
                        begin
                            key_tone = TONE_ERROR;
                        end
                        else if (pin_len != 3'd0)
                        begin
                            pending_next = key;
                            digits_next  = '0;
                            count_next   = '0;
                            key_tone     = TONE_ASK_CODE;
                        end
                        else
                        begin
                            fire     = 1'b1;
                            key_tone = TONE_OK;
                        end
                        ev_valid[1] = (key_tone != TONE_NONE);
                        ev_tone[1]  = key_tone;
                    end
                end
            end
            else
            begin
                idle_next = idle_tick;
                if (in_item.call_connected && (idle_tick > thr) && !c_warn)
                begin
                    ev_valid[1] = 1'b1;
                    ev_tone[1]  = TONE_WARNING;
                    warn_next   = 1'b1;
                end
                if (idle_tick > cfg.call_timeout_ms)
                begin
                    ev_valid[2] = 1'b1;
                    ev_hang[2]  = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            elapsed_next[i] = elapsed_reg[i];
            if (fire && (fire_key == 4'(i)))
            begin
                active_next[i]  = 1'b1;
                elapsed_next[i] = '0;
            end
            if (active_next[i])
            begin
                if (!is_key && (elapsed_next[i] != '1))
                begin
                    elapsed_next[i] = elapsed_next[i] + 16'd1;
                end
                if (elapsed_next[i] >= cfg.relay_pulse_ms)
                begin
                    active_next[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        n = '0;
        for (int j = 0; j < 3; j++)
        begin
            slot[j].tone          = TONE_NONE;
            slot[j].relay_outputs = active_next;
            slot[j].hang_up       = 1'b0;
            slot[j].last          = 1'b0;
        end
        for (int j = 0; j < 3; j++)
        begin
            if (ev_valid[j])
            begin
                slot[n].tone    = ev_tone[j];
                slot[n].hang_up = ev_hang[j];
                n = n + 2'd1;
            end
        end
        if (n == 2'd0)
        begin
            n = 2'd1;
        end
        slot[n - 2'd1].last = 1'b1;
    end

    always_comb
    begin
        push.count = in_xfer ? n : 2'd0;
        for (int j = 0; j < 3; j++)
        begin
            push.item[j] = slot[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_call_reg    <= 1'b0;
            idle_reg       <= '0;
            warn_reg       <= 1'b0;
            start_done_reg <= 1'b0;
            pending_reg    <= KEY_NONE;
            digits_reg     <= '0;
            count_reg      <= '0;
            active_reg     <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                elapsed_reg[i] <= '0;
            end
        end
        else if (in_xfer)
        begin
            in_call_reg    <= in_item.call_busy;
            idle_reg       <= idle_next;
            warn_reg       <= warn_next;
            start_done_reg <= start_done_next;
            pending_reg    <= pending_next;
            digits_reg     <= digits_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                elapsed_reg[i] <= elapsed_next[i];
            end
        end
    end

endmodule

// ----- rtl/dpr_res_fifo.sv -----
module dpr_res_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  dpr_pkg::dpr_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output dpr_pkg::dpr_out_t  out_data
);
    import dpr_pkg::*;

    dpr_out_t             mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_CNT_W-1:0] fill_reg;
    logic                 pop;

    assign out_valid = (fill_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = mem[rd_ptr_reg];
    assign room      = (fill_reg <= RES_CNT_W'(RES_DEPTH - MAX_RESULTS));

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            if (2'(j) < push.count)
            begin
                mem[wr_ptr_reg + RES_PTR_W'(j)] <= push.item[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(pop);
            fill_reg   <= fill_reg + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
        end
    end

endmodule

// ----- rtl/dtmf_pin_relay_controller.sv -----
// Channel   Direction  Payload     Transfer when
// in        input      dpr_in_t    in_valid && !in_stall
// out       output     dpr_out_t   out_valid && !out_stall
// cfg       input      64-bit data cfg_write (index selects the register)
//
// Each input item is decided in the cycle of its transfer and yields one to three
// results, which are written into a four-entry result queue at the transfer edge.
// The output side delivers one result per cycle while out_stall is low; a one-result item can then follow every cycle.
// Input stalls while fewer than three queue entries are free.
// Reset clears call state, relay timers and the queue; registers take their reset values.
module dtmf_pin_relay_controller #(
    parameter int NUM_KEYS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dpr_pkg::dpr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output dpr_pkg::dpr_out_t out_data,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import dpr_pkg::*;

    dpr_cfg_t  cfg;
    dpr_push_t push;
    logic      room;
    logic      in_xfer;

    assign in_stall = !room;
    assign in_xfer  = in_valid && room;

    dpr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dpr_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_xfer (in_xfer),
        .in_item (in_data),
        .cfg     (cfg),
        .push    (push)
    );

    dpr_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
